>>> hdl/rcwp_pkg.sv
// ----------------------------------------------------------------------------
// rcwp_pkg
// Shared constants and types of the raycaster column wall projection.
// ----------------------------------------------------------------------------
package rcwp_pkg;

    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;

    localparam int COL_W   = 10;
    localparam int MAP_W   = 8;
    localparam int POS_W   = 24;
    localparam int VEC_W   = 16;
    localparam int DIST_W  = 24;
    localparam int FRAC_W  = 16;
    localparam int HGT_W   = 16;
    localparam int TOP_W   = 16;
    localparam int FACE_W  = 2;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 24;
    localparam int ORD_W   = 30;

    localparam logic [DIST_W-1:0] DIST_MAX   = '1;
    localparam logic [HGT_W-1:0]  HEIGHT_MAX = '1;

    localparam logic [CIDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CIDX_W-1:0] REG_PLANE_Y = 3'd5;

    localparam logic signed [VEC_W-1:0] DIR_X_RST   = 16'sd16384;
    localparam logic signed [VEC_W-1:0] DIR_Y_RST   = 16'sd0;
    localparam logic signed [VEC_W-1:0] PLANE_X_RST = 16'sd0;
    localparam logic signed [VEC_W-1:0] PLANE_Y_RST = 16'sd10813;

    localparam logic [FACE_W-1:0] FACE_EAST  = 2'd0;
    localparam logic [FACE_W-1:0] FACE_WEST  = 2'd1;
    localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd2;
    localparam logic [FACE_W-1:0] FACE_NORTH = 2'd3;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [FACE_W-1:0] face;
        logic [FRAC_W-1:0] opos;
        logic [ORD_W-1:0]  ord;
        logic              divz;
        logic              sat;
        logic              neg;
    } t_ctx;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [FACE_W-1:0] face;
        logic [DIST_W-1:0] plen;
        logic [FRAC_W-1:0] frac;
        logic              hsat;
    } t_back;

endpackage

>>> hdl/rcwp_in_if.sv
// ----------------------------------------------------------------------------
// rcwp_in_if
// Column transaction channel: DDA hit result for one screen column.
// ----------------------------------------------------------------------------
interface rcwp_in_if;
    logic                          valid;
    logic                          ready;
    logic [rcwp_pkg::COL_W-1:0]    column;
    logic [rcwp_pkg::MAP_W-1:0]    map_x;
    logic [rcwp_pkg::MAP_W-1:0]    map_y;
    logic                          step_x_pos;
    logic                          step_y_pos;
    logic                          hit_side;

    modport source (output valid, column, map_x, map_y, step_x_pos, step_y_pos, hit_side,
                    input ready);
    modport sink   (input valid, column, map_x, map_y, step_x_pos, step_y_pos, hit_side,
                    output ready);
endinterface

>>> hdl/rcwp_out_if.sv
// ----------------------------------------------------------------------------
// rcwp_out_if
// Result transaction channel: projected wall slice for one column.
// ----------------------------------------------------------------------------
interface rcwp_out_if;
    logic                               valid;
    logic                               ready;
    logic [rcwp_pkg::COL_W-1:0]         column_tag;
    logic [rcwp_pkg::DIST_W-1:0]        perp_len;
    logic [rcwp_pkg::FRAC_W-1:0]        wall_frac;
    logic [rcwp_pkg::FACE_W-1:0]        face;
    logic [rcwp_pkg::HGT_W-1:0]         slice_hgt;
    logic signed [rcwp_pkg::TOP_W-1:0]  slice_top;

    modport source (output valid, column_tag, perp_len, wall_frac, face, slice_hgt,
                    slice_top, input ready);
    modport sink   (input valid, column_tag, perp_len, wall_frac, face, slice_hgt,
                    slice_top, output ready);
endinterface

>>> hdl/raycast_column_wall_projection.sv
// Throughput: one column per cycle; the pipeline has 49 register stages.
// The distance divider resolves one quotient bit per stage (24 stages), the
// height divider likewise (16 stages). A held result freezes the whole pipe.
// Reset: synchronous, clears all stage valid bits and loads the register
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
// raycast_column_wall_projection
// Per-column ray direction, perpendicular distance, wall hit fraction,
// face, projected height and top row, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
module raycast_column_wall_projection #(
    parameter int SCREEN_WIDTH  = rcwp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rcwp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rcwp_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [rcwp_pkg::CDAT_W-1:0]  i_cfg_data,
    rcwp_in_if.sink                      i_col,
    rcwp_out_if.source                   o_res
);

    localparam int SPAN_W   = 14;
    localparam int P_W      = 30;
    localparam int AP_W     = 28;
    localparam int RS       = 28;
    localparam int M_VAL    = (1 << RS) / SCREEN_WIDTH;
    localparam int M_W      = $clog2(M_VAL + 1);
    localparam int SPAN_MAX = (SCREEN_WIDTH > 1023) ? SCREEN_WIDTH : 2046 - SCREEN_WIDTH;
    localparam int Q_MAX    = (32768 * SPAN_MAX) / SCREEN_WIDTH;
    localparam int Q_W      = $clog2(Q_MAX + 1);
    localparam int RD_W     = ((Q_W + 1 > 16) ? Q_W + 1 : 16) + 1;
    localparam int NUM_W    = 26;
    localparam int AN_W     = 25;
    localparam int DVD_W    = AN_W + 14;
    localparam int DC_W     = ((DVD_W > RD_W + 23) ? DVD_W : RD_W + 23) + 1;
    localparam int HC_W     = rcwp_pkg::DIST_W + 16;
    localparam int NDB      = rcwp_pkg::DIST_W;
    localparam int NHB      = rcwp_pkg::HGT_W;

    // configuration registers
    logic [rcwp_pkg::POS_W-1:0]        r_pos_x, r_pos_y;
    logic signed [rcwp_pkg::VEC_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= rcwp_pkg::DIR_X_RST;
            r_dir_y   <= rcwp_pkg::DIR_Y_RST;
            r_plane_x <= rcwp_pkg::PLANE_X_RST;
            r_plane_y <= rcwp_pkg::PLANE_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcwp_pkg::REG_POS_X:   r_pos_x   <= i_cfg_data;
                rcwp_pkg::REG_POS_Y:   r_pos_y   <= i_cfg_data;
                rcwp_pkg::REG_DIR_X:   r_dir_x   <= i_cfg_data[rcwp_pkg::VEC_W-1:0];
                rcwp_pkg::REG_DIR_Y:   r_dir_y   <= i_cfg_data[rcwp_pkg::VEC_W-1:0];
                rcwp_pkg::REG_PLANE_X: r_plane_x <= i_cfg_data[rcwp_pkg::VEC_W-1:0];
                rcwp_pkg::REG_PLANE_Y: r_plane_y <= i_cfg_data[rcwp_pkg::VEC_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_o_v;
    assign en          = !r_o_v || o_res.ready;
    assign i_col.ready = en;

    // stage A: span products and distance numerator
    logic r_a_v;
    logic signed [P_W-1:0]   r_a_px, r_a_py;
    logic signed [NUM_W-1:0] r_a_num;
    logic [rcwp_pkg::COL_W-1:0]  r_a_col;
    logic [rcwp_pkg::FRAC_W-1:0] r_a_opos;
    logic r_a_side;

    logic signed [SPAN_W-1:0] n_span;
    logic signed [NUM_W-1:0]  n_num;
    always_comb begin
        n_span = $signed({3'b000, i_col.column, 1'b0}) - SPAN_W'(SCREEN_WIDTH);
        if (!i_col.hit_side)
            n_num = $signed({2'b00, i_col.map_x, 16'h0000}) - $signed({2'b00, r_pos_x})
                  + (i_col.step_x_pos ? NUM_W'(0) : NUM_W'(65536));
        else
            n_num = $signed({2'b00, i_col.map_y, 16'h0000}) - $signed({2'b00, r_pos_y})
                  + (i_col.step_y_pos ? NUM_W'(0) : NUM_W'(65536));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_px   <= P_W'(r_plane_x) * P_W'(n_span);
            r_a_py   <= P_W'(r_plane_y) * P_W'(n_span);
            r_a_num  <= n_num;
            r_a_col  <= i_col.column;
            r_a_side <= i_col.hit_side;
            r_a_opos <= i_col.hit_side ? r_pos_x[rcwp_pkg::FRAC_W-1:0]
                                       : r_pos_y[rcwp_pkg::FRAC_W-1:0];
        end
    end

    // stage B: reciprocal multiply for division by the screen width
    logic r_b_v;
    logic [AP_W-1:0] r_b_apx, r_b_apy;
    logic [Q_W-1:0]  r_b_q0x, r_b_q0y;
    logic r_b_nx, r_b_ny, r_b_side;
    logic signed [NUM_W-1:0] r_b_num;
    logic [rcwp_pkg::COL_W-1:0]  r_b_col;
    logic [rcwp_pkg::FRAC_W-1:0] r_b_opos;

    logic [AP_W-1:0]     n_apx, n_apy;
    logic [AP_W+M_W-1:0] n_mx, n_my;
    always_comb begin
        n_apx = AP_W'(r_a_px[P_W-1] ? -r_a_px : r_a_px);
        n_apy = AP_W'(r_a_py[P_W-1] ? -r_a_py : r_a_py);
        n_mx  = (AP_W+M_W)'(n_apx) * (AP_W+M_W)'(M_VAL);
        n_my  = (AP_W+M_W)'(n_apy) * (AP_W+M_W)'(M_VAL);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_apx  <= n_apx;
            r_b_apy  <= n_apy;
            r_b_q0x  <= n_mx[RS +: Q_W];
            r_b_q0y  <= n_my[RS +: Q_W];
            r_b_nx   <= r_a_px[P_W-1];
            r_b_ny   <= r_a_py[P_W-1];
            r_b_side <= r_a_side;
            r_b_num  <= r_a_num;
            r_b_col  <= r_a_col;
            r_b_opos <= r_a_opos;
        end
    end

    // stage C: quotient correction and sign
    logic r_c_v;
    logic signed [Q_W:0] r_c_qx, r_c_qy;
    logic r_c_side;
    logic signed [NUM_W-1:0] r_c_num;
    logic [rcwp_pkg::COL_W-1:0]  r_c_col;
    logic [rcwp_pkg::FRAC_W-1:0] r_c_opos;

    logic [AP_W:0] n_rx, n_ry;
    logic [Q_W-1:0] n_qx, n_qy;
    always_comb begin
        n_rx = {1'b0, r_b_apx} - (AP_W+1)'((AP_W+1)'(r_b_q0x) * (AP_W+1)'(SCREEN_WIDTH));
        n_ry = {1'b0, r_b_apy} - (AP_W+1)'((AP_W+1)'(r_b_q0y) * (AP_W+1)'(SCREEN_WIDTH));
        n_qx = r_b_q0x + Q_W'(n_rx >= (AP_W+1)'(SCREEN_WIDTH));
        n_qy = r_b_q0y + Q_W'(n_ry >= (AP_W+1)'(SCREEN_WIDTH));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_qx   <= r_b_nx ? -$signed({1'b0, n_qx}) : $signed({1'b0, n_qx});
            r_c_qy   <= r_b_ny ? -$signed({1'b0, n_qy}) : $signed({1'b0, n_qy});
            r_c_side <= r_b_side;
            r_c_num  <= r_b_num;
            r_c_col  <= r_b_col;
            r_c_opos <= r_b_opos;
        end
    end

    // stage D: ray direction, divisor select, face
    logic r_d_v;
    logic signed [RD_W-1:0]  r_d_div;
    logic signed [NUM_W-1:0] r_d_num;
    rcwp_pkg::t_ctx r_d_ctx;

    logic signed [RD_W-1:0] n_rdx, n_rdy;
    rcwp_pkg::t_ctx n_d_ctx;
    always_comb begin
        n_rdx = RD_W'(r_dir_x) + RD_W'(r_c_qx);
        n_rdy = RD_W'(r_dir_y) + RD_W'(r_c_qy);
        n_d_ctx      = '0;
        n_d_ctx.col  = r_c_col;
        n_d_ctx.opos = r_c_opos;
        if (!r_c_side) begin
            n_d_ctx.face = (n_rdx > 0) ? rcwp_pkg::FACE_EAST : rcwp_pkg::FACE_WEST;
            n_d_ctx.ord  = rcwp_pkg::ORD_W'(n_rdy);
        end else begin
            n_d_ctx.face = (n_rdy > 0) ? rcwp_pkg::FACE_SOUTH : rcwp_pkg::FACE_NORTH;
            n_d_ctx.ord  = rcwp_pkg::ORD_W'(n_rdx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_div <= r_c_side ? n_rdy : n_rdx;
            r_d_num <= r_c_num;
            r_d_ctx <= n_d_ctx;
        end
    end

    // stage E: magnitudes, sign and range flags, divider setup
    logic                  r_dv_v   [0:NDB];
    logic [DC_W-1:0]       r_dv_rem [0:NDB];
    logic [RD_W-1:0]       r_dv_d   [0:NDB];
    logic [NDB-1:0]        r_dv_q   [0:NDB];
    rcwp_pkg::t_ctx        r_dv_ctx [0:NDB];

    logic [AN_W-1:0] n_an;
    logic [RD_W-1:0] n_ad;
    rcwp_pkg::t_ctx  n_e_ctx;
    always_comb begin
        n_an = AN_W'(r_d_num[NUM_W-1] ? -r_d_num : r_d_num);
        n_ad = r_d_div[RD_W-1] ? RD_W'(-r_d_div) : RD_W'(r_d_div);
        n_e_ctx      = r_d_ctx;
        n_e_ctx.divz = (r_d_div == '0);
        n_e_ctx.neg  = r_d_num[NUM_W-1] ^ r_d_div[RD_W-1];
        n_e_ctx.sat  = (DC_W'(n_an) >= (DC_W'(n_ad) << 10));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0] <= DC_W'(n_an) << 14;
            r_dv_d[0]   <= n_ad;
            r_dv_q[0]   <= '0;
            r_dv_ctx[0] <= n_e_ctx;
        end
    end

    // distance divider: one quotient bit per stage
    for (genvar k = 0; k < NDB; k++) begin : g_ddiv
        localparam int B = NDB - 1 - k;
        logic [DC_W-1:0] n_t;
        logic            n_ge;
        assign n_t  = DC_W'(r_dv_d[k]) << B;
        assign n_ge = (r_dv_rem[k] >= n_t);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[k+1] <= n_ge ? r_dv_rem[k] - n_t : r_dv_rem[k];
                r_dv_d[k+1]   <= r_dv_d[k];
                r_dv_q[k+1]   <= r_dv_q[k] | (NDB'(n_ge) << B);
                r_dv_ctx[k+1] <= r_dv_ctx[k];
            end
        end
    end

    // stage F: distance with saturation and clamp
    logic r_f_v;
    logic [rcwp_pkg::DIST_W-1:0] r_f_dist;
    rcwp_pkg::t_ctx r_f_ctx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_dv_ctx[NDB].divz)
                r_f_dist <= rcwp_pkg::DIST_MAX;
            else if (r_dv_ctx[NDB].neg)
                r_f_dist <= '0;
            else if (r_dv_ctx[NDB].sat)
                r_f_dist <= rcwp_pkg::DIST_MAX;
            else
                r_f_dist <= r_dv_q[NDB];
            r_f_ctx <= r_dv_ctx[NDB];
        end
    end

    // stage G: hit coordinate product
    logic r_g_v;
    logic [rcwp_pkg::ORD_W-1:0]  r_g_prod;
    logic [rcwp_pkg::DIST_W-1:0] r_g_dist;
    rcwp_pkg::t_ctx r_g_ctx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_prod <= rcwp_pkg::ORD_W'(rcwp_pkg::ORD_W'(r_f_dist) * r_f_ctx.ord);
            r_g_dist <= r_f_dist;
            r_g_ctx  <= r_f_ctx;
        end
    end

    // stage H: wall fraction, height divider setup
    logic               r_hv_v   [0:NHB];
    logic [HC_W-1:0]    r_hv_rem [0:NHB];
    logic [NHB-1:0]     r_hv_q   [0:NHB];
    rcwp_pkg::t_back    r_hv_bk  [0:NHB];

    rcwp_pkg::t_back n_h_bk;
    always_comb begin
        n_h_bk.col  = r_g_ctx.col;
        n_h_bk.face = r_g_ctx.face;
        n_h_bk.plen = r_g_dist;
        n_h_bk.frac = r_g_ctx.opos + r_g_prod[rcwp_pkg::ORD_W-1:14];
        n_h_bk.hsat = (HC_W'(r_g_dist) <= HC_W'(SCREEN_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hv_rem[0] <= HC_W'(SCREEN_HEIGHT) << 16;
            r_hv_q[0]   <= '0;
            r_hv_bk[0]  <= n_h_bk;
        end
    end

    for (genvar j = 0; j < NHB; j++) begin : g_hdiv
        localparam int B = NHB - 1 - j;
        logic [HC_W-1:0] n_t;
        logic            n_ge;
        assign n_t  = HC_W'(r_hv_bk[j].plen) << B;
        assign n_ge = (r_hv_rem[j] >= n_t);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_hv_rem[j+1] <= n_ge ? r_hv_rem[j] - n_t : r_hv_rem[j];
                r_hv_q[j+1]   <= r_hv_q[j] | (NHB'(n_ge) << B);
                r_hv_bk[j+1]  <= r_hv_bk[j];
            end
        end
    end

    // output register
    logic [rcwp_pkg::HGT_W-1:0] n_hgt;
    assign n_hgt = r_hv_bk[NHB].hsat ? rcwp_pkg::HEIGHT_MAX : r_hv_q[NHB];

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.column_tag <= r_hv_bk[NHB].col;
            o_res.perp_len   <= r_hv_bk[NHB].plen;
            o_res.wall_frac  <= r_hv_bk[NHB].frac;
            o_res.face       <= r_hv_bk[NHB].face;
            o_res.slice_hgt  <= n_hgt;
            o_res.slice_top  <= rcwp_pkg::TOP_W'(SCREEN_HEIGHT / 2)
                              - $signed({1'b0, n_hgt[rcwp_pkg::HGT_W-1:1]});
        end
    end

    assign o_res.valid = r_o_v;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_o_v <= 1'b0;
            for (int i = 0; i <= NDB; i++) r_dv_v[i] <= 1'b0;
            for (int i = 0; i <= NHB; i++) r_hv_v[i] <= 1'b0;
        end else if (en) begin
            r_a_v     <= i_col.valid;
            r_b_v     <= r_a_v;
            r_c_v     <= r_b_v;
            r_d_v     <= r_c_v;
            r_dv_v[0] <= r_d_v;
            for (int i = 0; i < NDB; i++) r_dv_v[i+1] <= r_dv_v[i];
            r_f_v     <= r_dv_v[NDB];
            r_g_v     <= r_f_v;
            r_hv_v[0] <= r_g_v;
            for (int i = 0; i < NHB; i++) r_hv_v[i+1] <= r_hv_v[i];
            r_o_v     <= r_hv_v[NHB];
        end
    end

endmodule

>>> hdl/rcwp_checker.sv
// ----------------------------------------------------------------------------
// rcwp_checker
// Port-level assertions for the column wall projection, bound to the top.
// ----------------------------------------------------------------------------
module rcwp_checker #(
    parameter int SCREEN_HEIGHT = rcwp_pkg::SCREEN_HEIGHT_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [rcwp_pkg::DIST_W-1:0]        i_perp_len,
    input logic [rcwp_pkg::HGT_W-1:0]         i_slice_hgt,
    input logic signed [rcwp_pkg::TOP_W-1:0]  i_slice_top
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_perp_len)
            && $stable(i_slice_hgt) && $stable(i_slice_top))
        else $error("held result transaction changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_slice_top == rcwp_pkg::TOP_W'(SCREEN_HEIGHT / 2)
            - $signed({1'b0, i_slice_hgt[rcwp_pkg::HGT_W-1:1]}))
        else $error("wall top inconsistent with height");

    a_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_perp_len == '0 |-> i_slice_hgt == rcwp_pkg::HEIGHT_MAX)
        else $error("zero distance without saturated height");

endmodule

bind raycast_column_wall_projection rcwp_checker #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_col.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_perp_len  (o_res.perp_len),
    .i_slice_hgt (o_res.slice_hgt),
    .i_slice_top (o_res.slice_top)
);
